### src/mlgd_pkg.sv
package mlgd_pkg;

    localparam int MEM_DEPTH = 4096;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CNT_W     = ADDR_W;
    localparam int EDGE_W    = CNT_W + 1;
    localparam int CHAN_W    = 8;
    localparam int SUM_W     = 12;

    localparam logic [3:0] SIZE_LOG2_RESET = 4'd8;
    localparam logic [3:0] SIZE_LOG2_MIN   = 4'd1;
    localparam logic [3:0] SIZE_LOG2_MAX   = 4'd12;

    // Divisor select: weight total of the taps that fall inside the image
    localparam logic [1:0] DIV16 = 2'd0;
    localparam logic [1:0] DIV12 = 2'd1;
    localparam logic [1:0] DIV9  = 2'd2;

    // floor(a/3) == (a*683)>>11 for a < 2048; floor(s/9) == (s*3641)>>15 for s < 32768
    localparam logic [10:0] RECIP3 = 11'd683;
    localparam logic [11:0] RECIP9 = 12'd3641;

    typedef logic [3:0]        size_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [SUM_W-1:0]  sum_t;

    // index 0 red, 1 green, 2 blue, 3 alpha
    typedef logic [3:0][CHAN_W-1:0] rgba_t;

    typedef struct packed {
        rgba_t up0;
        rgba_t up1;
        rgba_t up2;
        rgba_t mid0;
        rgba_t mid1;
        rgba_t mid2;
    } taps_t;

    function automatic sum_t chan_sum(
        input chan_t u2, input chan_t u1, input chan_t u0,
        input chan_t m2, input chan_t m1, input chan_t m0,
        input chan_t r1, input chan_t r0, input chan_t p,
        input logic  has_left, input logic has_top
    );
        sum_t s;
        s = {2'b00, m1, 2'b00} + {3'b000, m0, 1'b0} + {3'b000, r0, 1'b0} + {4'b0000, p};
        if (has_top) begin
            s = s + {3'b000, u1, 1'b0} + {4'b0000, u0};
        end
        if (has_left) begin
            s = s + {3'b000, m2, 1'b0} + {4'b0000, r1};
        end
        if (has_top && has_left) begin
            s = s + {4'b0000, u2};
        end
        return s;
    endfunction

    function automatic chan_t div_chan(input sum_t s, input logic [1:0] sel);
        logic [SUM_W-3:0] quarter;
        logic [20:0]      p12;
        logic [23:0]      p9;
        chan_t            q;
        quarter = s[SUM_W-1:2];
        p12     = 21'(quarter) * 21'(RECIP3);
        p9      = 24'(s) * 24'(RECIP9);
        case (sel)
            DIV16:   q = s[SUM_W-1:4];
            DIV12:   q = p12[18:11];
            DIV9:    q = p9[22:15];
            default: q = s[SUM_W-1:4];
        endcase
        return q;
    endfunction

endpackage

### src/mlgd_pix_if.sv
interface mlgd_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;

    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    output ready);
endinterface

### src/mlgd_res_if.sv
interface mlgd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_alpha, output last, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_alpha, input last, output ready);
endinterface

### src/mip_level_gauss_downsample.sv
// Mip level downsampler, RGBA8, 3x3 binomial (1 2 1) filter, half edge length.
//
// pixel:  source pixels of a square level, raster order, one per transfer.
// result: one filtered pixel per transfer; last marks the final pixel of the level.
// cfg_we/cfg_data: writes size_log2 (edge = 2**size_log2, clamped to 1..12) and
//   restarts the level at row 0, column 0. Write only while the block is idle.
//
// A result is due for every source pixel at odd row and odd column; it is registered
// in s1, then s2, then the output register. Throughput is one source pixel per cycle
// unless the result side stalls, set by the single read and write port of each line
// memory (two 4096 x 32 memories holding the last even and last odd source rows).
// Pixels follow back to back; a stalled result sits in the output register while
// the two stages behind it keep filling, and pixel.ready drops only once all are full.
// After the last pixel the counters wrap and the next pixel starts a new level.
//
// Reset: size_log2 = 8, counters at zero, pipeline empty. The line memories are
// not cleared; every entry is written before a result uses it.
module mip_level_gauss_downsample (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  mlgd_pkg::size_t cfg_data,
    mlgd_pix_if.sink        pixel,
    mlgd_res_if.source      result
);
    import mlgd_pkg::*;

    typedef struct packed {
        logic  is_out;
        logic  has_left;
        logic  has_top;
        logic  last;
        rgba_t px;
        rgba_t r0;
        rgba_t r1;
    } s1_t;

    typedef struct packed {
        logic [3:0][SUM_W-1:0] sum;
        logic [1:0]            div_sel;
        logic                  last;
    } s2_t;

    size_t size_reg;
    size_t size_eff;
    cnt_t  last_idx;
    cnt_t  col_reg;
    cnt_t  col_next;
    cnt_t  row_reg;
    cnt_t  row_next;
    rgba_t recent0_reg;
    rgba_t recent1_reg;
    rgba_t px_in;
    logic  col_end;
    logic  row_end;

    logic  s1_valid_reg;
    s1_t   s1_reg;
    s1_t   s1_next;
    logic  s2_valid_reg;
    s2_t   s2_reg;
    s2_t   s2_next;
    logic  out_valid_reg;
    rgba_t out_px_reg;
    logic  out_last_reg;

    logic  pix_xfer;
    logic  s1_adv;
    logic  s2_adv;
    taps_t taps;

    always_comb
    begin
        if (size_reg inside {[SIZE_LOG2_MIN:SIZE_LOG2_MAX]})
        begin
            size_eff = size_reg;
        end
        else if (size_reg < SIZE_LOG2_MIN)
        begin
            size_eff = SIZE_LOG2_MIN;
        end
        else
        begin
            size_eff = SIZE_LOG2_MAX;
        end
        last_idx = CNT_W'((EDGE_W'(1) << size_eff) - EDGE_W'(1));
    end

    assign px_in   = {pixel.alpha, pixel.blue, pixel.green, pixel.red};
    assign col_end = (col_reg == last_idx);
    assign row_end = (row_reg == last_idx);

    // Handshake chain; non-output items leave s1 without entering s2
    assign s2_adv      = s2_valid_reg && (!out_valid_reg || result.ready);
    assign s1_adv      = s1_valid_reg && (!s1_reg.is_out || !s2_valid_reg || s2_adv);
    assign pixel.ready = !s1_valid_reg || s1_adv;
    assign pix_xfer    = pixel.valid && pixel.ready;

    always_comb
    begin
        col_next = col_reg + CNT_W'(1);
        row_next = row_reg;
        if (col_end)
        begin
            col_next = '0;
            row_next = row_end ? '0 : row_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        s1_next.is_out   = row_reg[0] && col_reg[0];
        s1_next.has_left = (col_reg >= CNT_W'(3));
        s1_next.has_top  = (row_reg >= CNT_W'(3));
        s1_next.last     = col_end && row_end;
        s1_next.px       = px_in;
        s1_next.r0       = recent0_reg;
        s1_next.r1       = recent1_reg;
    end

    mlgd_line_store u_line_store (
        .clk      (clk),
        .wr_en    (pix_xfer),
        .wr_upper (row_reg[0]),
        .addr     (col_reg),
        .wdata    (px_in),
        .rd_en    (pix_xfer),
        .shift_en (s1_adv),
        .taps     (taps)
    );

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            s2_next.sum[c] = chan_sum(taps.up2[c], taps.up1[c], taps.up0[c],
                                      taps.mid2[c], taps.mid1[c], taps.mid0[c],
                                      s1_reg.r1[c], s1_reg.r0[c], s1_reg.px[c],
                                      s1_reg.has_left, s1_reg.has_top);
        end
        if (s1_reg.has_top && s1_reg.has_left)
        begin
            s2_next.div_sel = DIV16;
        end
        else if (s1_reg.has_top || s1_reg.has_left)
        begin
            s2_next.div_sel = DIV12;
        end
        else
        begin
            s2_next.div_sel = DIV9;
        end
        s2_next.last = s1_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_LOG2_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            recent0_reg   <= '0;
            recent1_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg    <= cfg_data;
                col_reg     <= '0;
                row_reg     <= '0;
                recent0_reg <= '0;
                recent1_reg <= '0;
            end
            else if (pix_xfer)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                recent0_reg <= px_in;
                recent1_reg <= recent0_reg;
            end

            if (pix_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv && s1_reg.is_out)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_xfer)
        begin
            s1_reg <= s1_next;
        end
        if (s1_adv && s1_reg.is_out)
        begin
            s2_reg <= s2_next;
        end
        if (s2_adv)
        begin
            for (int c = 0; c < 4; c++)
            begin
                out_px_reg[c] <= div_chan(s2_reg.sum[c], s2_reg.div_sel);
            end
            out_last_reg <= s2_reg.last;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_red   = out_px_reg[0];
    assign result.out_green = out_px_reg[1];
    assign result.out_blue  = out_px_reg[2];
    assign result.out_alpha = out_px_reg[3];
    assign result.last      = out_last_reg;

    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        pix_xfer && row_reg[0] && col_reg[0] |=> s1_valid_reg && s1_reg.is_out)
        else $error("odd/odd pixel not marked as producing a result");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> col_reg == '0 && row_reg == '0)
        else $error("size write did not restart the level");

    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        pix_xfer && col_end && row_end |=> col_reg == '0 && row_reg == '0)
        else $error("counters did not wrap after the last pixel");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && out_valid_reg && !result.ready |=> s2_valid_reg && $stable(s2_reg))
        else $error("filter stage lost its sum during an output stall");

endmodule

### src/mlgd_line_store.sv
module mlgd_line_store (
    input  logic            clk,
    input  logic            wr_en,
    input  logic            wr_upper,
    input  mlgd_pkg::addr_t addr,
    input  mlgd_pkg::rgba_t wdata,
    input  logic            rd_en,
    input  logic            shift_en,
    output mlgd_pkg::taps_t taps
);
    import mlgd_pkg::*;

    rgba_t upper_mem  [MEM_DEPTH];
    rgba_t middle_mem [MEM_DEPTH];

    rgba_t up_rd_reg;
    rgba_t mid_rd_reg;
    rgba_t up1_reg;
    rgba_t up2_reg;
    rgba_t mid1_reg;
    rgba_t mid2_reg;

    // Read-first: a read and write of the same entry in one cycle returns the older row
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            up_rd_reg <= upper_mem[addr];
        end
        if (wr_en && wr_upper)
        begin
            upper_mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mid_rd_reg <= middle_mem[addr];
        end
        if (wr_en && !wr_upper)
        begin
            middle_mem[addr] <= wdata;
        end
    end

    // Column window: taps at x-1 and x-2 from earlier reads
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            up1_reg  <= up_rd_reg;
            up2_reg  <= up1_reg;
            mid1_reg <= mid_rd_reg;
            mid2_reg <= mid1_reg;
        end
    end

    assign taps.up0  = up_rd_reg;
    assign taps.up1  = up1_reg;
    assign taps.up2  = up2_reg;
    assign taps.mid0 = mid_rd_reg;
    assign taps.mid1 = mid1_reg;
    assign taps.mid2 = mid2_reg;

endmodule

### tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mlgd_pkg::*;

    typedef struct packed {
        rgba_t px;
        logic  last;
    } texel_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  cfg_we;
    size_t cfg_data;

    mlgd_pix_if pix_bus ();
    mlgd_res_if res_bus ();

    mip_level_gauss_downsample dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .pixel    (pix_bus),
        .result   (res_bus)
    );

    // shadow of the block: line stores, two most recent pixels, raster position
    rgba_t       even_row [MEM_DEPTH];
    rgba_t       odd_row  [MEM_DEPTH];
    rgba_t       prev_px  [2];
    int unsigned col_pos;
    int unsigned row_pos;
    size_t       size_reg;
    texel_t      halfres_q [$];

    bit tx_idle;
    bit rx_idle;
    int sink_hold_cycles = 0;
    int pixels_sent      = 0;
    int texels_checked   = 0;
    int size_writes      = 0;
    int mismatches       = 0;

    always #5 clk = ~clk;

    function automatic int unsigned edge_len_of(input size_t s);
        size_t c;
        c = s;
        if (c < SIZE_LOG2_MIN) c = SIZE_LOG2_MIN;
        if (c > SIZE_LOG2_MAX) c = SIZE_LOG2_MAX;
        return 32'd1 << c;
    endfunction

    function automatic rgba_t rand_pixel();
        rgba_t p;
        for (int c = 0; c < 4; c++)
        begin
            case ($urandom_range(0, 7))
                0:       p[c] = 8'h00;
                1:       p[c] = 8'hFF;
                default: p[c] = 8'($urandom);
            endcase
        end
        return p;
    endfunction

    task automatic predict_pixel(input rgba_t px);
        int unsigned el;
        int unsigned x;
        int unsigned y;
        int unsigned wsum;
        int unsigned sum;
        logic        has_left;
        logic        has_top;
        texel_t      want;
        el = edge_len_of(size_reg);
        x  = col_pos;
        y  = row_pos;
        if (x >= el || y >= el)
        begin
            x = 0;
            y = 0;
        end
        // odd row, odd column closes a 3x3 window centred one up and one left
        if ((x % 2) == 1 && (y % 2) == 1)
        begin
            has_left = (x >= 3);
            has_top  = (y >= 3);
            wsum = 9;
            if (has_top) wsum += 3;
            if (has_left) wsum += 3;
            if (has_top && has_left) wsum += 1;
            for (int c = 0; c < 4; c++)
            begin
                sum = 0;
                if (has_top)
                begin
                    if (has_left) sum += odd_row[x-2][c];
                    sum += 2 * odd_row[x-1][c] + odd_row[x][c];
                end
                if (has_left) sum += 2 * even_row[x-2][c] + prev_px[1][c];
                sum += 4 * even_row[x-1][c] + 2 * even_row[x][c] + 2 * prev_px[0][c] + px[c];
                want.px[c] = 8'(sum / wsum);
            end
            want.last = (x == el - 1 && y == el - 1);
            halfres_q.insert(halfres_q.size(), want);
        end
        if ((y % 2) == 0)
        begin
            even_row[x] = px;
        end
        else
        begin
            if (x >= 2) odd_row[x-2] = prev_px[1];
            if (x == el - 1)
            begin
                odd_row[x-1] = prev_px[0];
                odd_row[x]   = px;
            end
        end
        prev_px[1] = prev_px[0];
        prev_px[0] = px;
        x++;
        if (x >= el)
        begin
            x = 0;
            y++;
            if (y >= el) y = 0;
        end
        col_pos = x;
        row_pos = y;
    endtask

    task automatic write_size(input size_t v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        size_reg   = v;
        col_pos    = 0;
        row_pos    = 0;
        prev_px[0] = '0;
        prev_px[1] = '0;
        size_writes++;
    endtask

    task automatic send_pixel(input rgba_t px);
        int gap;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.red   <= px[0];
        pix_bus.green <= px[1];
        pix_bus.blue  <= px[2];
        pix_bus.alpha <= px[3];
        @(posedge clk);
        while (!pix_bus.ready) @(posedge clk);
        predict_pixel(px);
        pixels_sent++;
    endtask

    task automatic send_random(input int n);
        repeat (n) send_pixel(rand_pixel());
    endtask

    // block idle: nothing outstanding, and pixels with no result have left the pipe
    task automatic drain();
        pix_bus.valid <= 1'b0;
        while (halfres_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic check_result();
        texel_t want;
        rgba_t  got;
        got = {res_bus.out_alpha, res_bus.out_blue, res_bus.out_green, res_bus.out_red};
        if (halfres_q.size() == 0)
        begin
            $display("%0t: unexpected result rgba=%h last=%b", $time, got, res_bus.last);
            mismatches++;
        end
        else
        begin
            want = halfres_q.pop_front();
            texels_checked++;
            if (got[0] !== want.px[0] || got[1] !== want.px[1] || got[2] !== want.px[2] ||
                got[3] !== want.px[3] || res_bus.last !== want.last)
            begin
                $display("%0t: expected r=%h g=%h b=%h a=%h last=%b,", $time,
                         want.px[0], want.px[1], want.px[2], want.px[3], want.last);
                $display("%0t:      got r=%h g=%h b=%h a=%h last=%b", $time,
                         got[0], got[1], got[2], got[3], res_bus.last);
                mismatches++;
            end
        end
    endtask

    // result side: random per-transfer gaps, plus one long hold when asked
    initial
    begin
        int gap;
        res_bus.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            gap = rx_idle ? $urandom_range(0, 3) : 0;
            if (gap > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            forever
            begin
                @(posedge clk);
                if (res_bus.valid) break;
                if (sink_hold_cycles > 0)
                begin
                    res_bus.ready <= 1'b0;
                    repeat (sink_hold_cycles) @(posedge clk);
                    sink_hold_cycles = 0;
                    res_bus.ready <= 1'b1;
                end
            end
            check_result();
        end
    end

    // two rows at the reset edge length of 256, no config write
    task automatic test_reset_size();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_random(512);
        drain();
    endtask

    task automatic test_corner_values();
        rgba_t p;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        // size 0 clamps to edge 2; full-scale sum divided by 9
        write_size(4'd0);
        repeat (4) send_pixel({4{8'hFF}});
        drain();
        // edge 2, all zero, then wrap into a second level
        write_size(SIZE_LOG2_MIN);
        repeat (4) send_pixel('0);
        send_pixel({8'hFF, 8'h00, 8'hFF, 8'h00});
        send_pixel({8'h00, 8'hFF, 8'h00, 8'hFF});
        send_pixel({8'hFF, 8'hFF, 8'h00, 8'h00});
        send_pixel({8'h00, 8'h00, 8'hFF, 8'hFF});
        drain();
        // edge 4: corner, top edge, left edge and interior divisors
        write_size(4'd2);
        tx_idle = 1'b0;
        for (int i = 0; i < 16; i++)
        begin
            p[0] = (i % 2 == 1) ? 8'hFF : 8'h00;
            p[1] = (i % 3 == 0) ? 8'hFF : 8'h00;
            p[2] = ~p[0];
            p[3] = 8'(i * 17);
            send_pixel(p);
        end
        drain();
    endtask

    // largest edge codes: a partial first row produces no result; the next write restarts
    task automatic test_largest_edge();
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        write_size(4'd15);
        send_random(24);
        drain();
        tx_idle = 1'b1;
        rx_idle = 1'b0;
        write_size(SIZE_LOG2_MAX);
        send_random(24);
        drain();
    endtask

    task automatic test_random_levels();
        int          target;
        int          n;
        int unsigned lvl;
        size_t       s;
        target = pixels_sent + 200;
        while (pixels_sent < target)
        begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
            begin
                // large edge, first row only: no results, checks restart on next write
                s = size_t'($urandom_range(6, 15));
                n = $urandom_range(1, 40);
            end
            else
            begin
                s   = size_t'($urandom_range(0, 4));
                lvl = edge_len_of(s) * edge_len_of(s);
                case ($urandom_range(0, 2))
                    0:       n = $urandom_range(1, lvl);
                    1:       n = lvl;
                    default: n = 2 * lvl;
                endcase
            end
            if (n > target - pixels_sent) n = target - pixels_sent;
            write_size(s);
            send_random(n);
            drain();
        end
    endtask

    // output held off while input keeps coming: pipeline fills, input must stall
    task automatic test_output_stall();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        write_size(4'd3);
        sink_hold_cycles = 300;
        send_random(128);
        drain();
    endtask

    task automatic finish_run();
        int waited;
        pix_bus.valid <= 1'b0;
        waited = 0;
        while (halfres_q.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (halfres_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, halfres_q.size());
            mismatches += halfres_q.size();
        end
        $display("Streamed %0d source pixels across %0d size writes, clamped codes included;",
                 pixels_sent, size_writes);
        $display("compared %0d downsampled pixels, edges 2 to 256, %0d errors.",
                 texels_checked, mismatches);
        if (mismatches == 0)
        begin
            $display("mip_level_gauss_downsample: match");
        end
        else
        begin
            $display("mip_level_gauss_downsample: mismatch");
        end
        $finish;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        pix_bus.valid = 1'b0;
        pix_bus.red   = '0;
        pix_bus.green = '0;
        pix_bus.blue  = '0;
        pix_bus.alpha = '0;
        size_reg      = SIZE_LOG2_RESET;
        col_pos       = 0;
        row_pos       = 0;
        prev_px[0]    = '0;
        prev_px[1]    = '0;
        tx_idle       = 1'b0;
        rx_idle       = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_size();
        test_corner_values();
        test_largest_edge();
        test_random_levels();
        test_output_stall();
        finish_run();
    end

    initial
    begin
        #10_000_000;
        $display("%0t: timeout, %0d results outstanding", $time, halfres_q.size());
        $display("mip_level_gauss_downsample: mismatch");
        $finish;
    end

endmodule
